### rtl/core/plbc_pkg.sv
// Shared types and constants for the pinned LRU block cache.
// No dependencies; the interfaces and the top level refer to it by scoped names.
package plbc_pkg;

  localparam int DEV_W   = 16;
  localparam int BLK_W   = 32;
  localparam int PIN_W   = 16;
  localparam int STAT_W  = 3;
  localparam int SLOT_W  = 8;
  localparam int OP_W    = 2;
  localparam int MAXE_W  = 9;
  localparam int MAXF_W  = 7;
  localparam int CFG_W   = 9;
  localparam int CIDX_W  = 1;
  localparam int KEY_W   = 1 + DEV_W + BLK_W;

  localparam logic [PIN_W-1:0] PIN_MAX = '1;

  // Request codes
  localparam logic [OP_W-1:0] OP_GET   = 2'd0;
  localparam logic [OP_W-1:0] OP_PUT   = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

  // Result codes
  localparam logic [STAT_W-1:0] STAT_HIT       = 3'd0;
  localparam logic [STAT_W-1:0] STAT_MISS      = 3'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] STAT_PUT_DONE  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_PUT_UNK   = 3'd4;
  localparam logic [STAT_W-1:0] STAT_PUT_UNPIN = 3'd5;
  localparam logic [STAT_W-1:0] STAT_WRITEBACK = 3'd6;
  localparam logic [STAT_W-1:0] STAT_IDLE      = 3'd7;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_MAX_ENTRIES = 1'd0;
  localparam logic [CIDX_W-1:0] CFG_MAX_FLUSHES = 1'd1;

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE, ST_GET, ST_WALK_RD, ST_WALK_CHK, ST_EV_RD, ST_EV_KEY,
    ST_CHK, ST_SCAN, ST_HIT_RD, ST_HIT_UPD, ST_MISS_RD, ST_MISS_WR,
    ST_PUT_RD, ST_PUT_UPD, ST_PUT_LRU, ST_FL_NEXT, ST_FL_RD, ST_FL_KEY,
    ST_RM_RD, ST_RM_LINK, ST_RM_OFF, ST_PU_RD, ST_PU_W1, ST_PU_W2, ST_EMIT
  } plbc_state_t;

endpackage

### rtl/core/plbc_in_if.sv
// Request channel of the block cache: valid/ready plus operation and key.
// Depends on plbc_pkg for field widths.
interface plbc_in_if;
  logic                         valid;
  logic                         ready;
  logic [plbc_pkg::OP_W-1:0]    operation;
  logic [plbc_pkg::DEV_W-1:0]   device;
  logic [plbc_pkg::BLK_W-1:0]   block_number;

  modport source (output valid, operation, device, block_number, input ready);
  modport sink   (input valid, operation, device, block_number, output ready);
endinterface

### rtl/core/plbc_out_if.sv
// Result channel of the block cache: valid/ready plus one result beat.
// Depends on plbc_pkg for field widths.
interface plbc_out_if;
  logic                         valid;
  logic                         ready;
  logic [plbc_pkg::STAT_W-1:0]  status;
  logic [plbc_pkg::SLOT_W-1:0]  slot;
  logic [plbc_pkg::DEV_W-1:0]   out_device;
  logic [plbc_pkg::BLK_W-1:0]   out_block;
  logic [plbc_pkg::PIN_W-1:0]   pin_count;
  logic                         last;

  modport source (output valid, status, slot, out_device, out_block, pin_count, last,
                  input ready);
  modport sink   (input valid, status, slot, out_device, out_block, pin_count, last,
                  output ready);
endinterface

### rtl/core/plbc_ram.sv
// Simple dual-port synchronous RAM: one write port, one registered read port.
// No dependencies.
module plbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; a same-cycle read returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/pinned_lru_block_cache.sv
// Pinned LRU block cache top level: sequencer, list registers and slot RAMs.
// Depends on plbc_pkg, plbc_in_if, plbc_out_if and plbc_ram.
//
//   channel   dir   handshake        beat contents
//   in_req    in    valid/ready      operation, device, block_number
//   out_rsp   out   valid/ready      status, slot, out_device, out_block, pin_count, last
//   cfg_*     in    cfg_we only      cfg_index, cfg_data
//
// One request at a time. A key lookup scans the key RAM one slot per cycle; an
// eviction walks the LRU list entry by entry, and a flush pass emits one writeback
// beat per flushed slot. After reset a clearing pass invalidates slots and fills
// the free stack; no request is taken meanwhile. A stalled result holds the
// sequencer in place until the beat is taken.
module pinned_lru_block_cache #(
  parameter int CAPACITY    = 256,
  parameter int FLUSH_LIMIT = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  plbc_in_if.sink                       in_req,
  plbc_out_if.source                    out_rsp,
  input  logic                          cfg_we,
  input  logic [plbc_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [plbc_pkg::CFG_W-1:0]    cfg_data
);

  localparam int IW   = $clog2(CAPACITY);
  localparam int LW   = IW + 1;              // link with nil flag on top
  localparam int CW   = IW + 1;              // counts up to CAPACITY
  localparam int CMPW = (CW > plbc_pkg::MAXE_W) ? CW : plbc_pkg::MAXE_W;
  localparam logic [LW-1:0] NIL = {1'b1, {IW{1'b0}}};

  plbc_pkg::plbc_state_t state, state_next;
  plbc_pkg::plbc_state_t rm_ret, pu_ret, emit_ret;

  logic [plbc_pkg::MAXE_W-1:0] max_entries;
  logic [plbc_pkg::MAXF_W-1:0] max_flushes;

  logic [plbc_pkg::OP_W-1:0]  op_r;
  logic [plbc_pkg::DEV_W-1:0] dev_r;
  logic [plbc_pkg::BLK_W-1:0] blk_r;
  logic [IW-1:0] s;
  logic [IW-1:0] init_idx;
  logic [CW-1:0] scan_idx;
  logic          cmp_v;
  logic [IW-1:0] cmp_idx;
  logic [CW-1:0] free_top;
  logic [CW-1:0] resident;
  logic [LW-1:0] fh, ft, lh, lt;
  logic [plbc_pkg::MAXF_W-1:0] fl_k;
  logic [plbc_pkg::PIN_W-1:0]  pins_r;
  logic rm_f, rm_l, rm_free;
  logic fon, lon;
  logic pu_lru, pu_on;
  logic [LW-1:0] pu_tail;

  logic [plbc_pkg::STAT_W-1:0] res_status;
  logic [IW-1:0]               res_slot;
  logic [plbc_pkg::DEV_W-1:0]  res_dev;
  logic [plbc_pkg::BLK_W-1:0]  res_blk;
  logic [plbc_pkg::PIN_W-1:0]  res_pins;
  logic                        res_last;
  logic                        out_valid;

  // RAM ports
  logic                       key_we, pins_we, fl_we, free_we;
  logic [IW-1:0]              key_wa, key_ra, pins_wa, pins_ra, fl_wa, fl_ra;
  logic [IW-1:0]              free_wa, free_ra;
  logic [plbc_pkg::KEY_W-1:0] key_wd, key_rd;
  logic [plbc_pkg::PIN_W-1:0] pins_wd, pins_rd;
  logic                       fl_wd, fl_rd;
  logic [IW-1:0]              free_wd, free_rd;
  logic                       fp_we, fn_we, lp_we, ln_we;
  logic [IW-1:0]              fp_wa, fn_wa, lp_wa, ln_wa, lk_ra;
  logic [LW:0]                fp_wd, lp_wd, fp_rd, lp_rd;
  logic [LW-1:0]              fn_wd, ln_wd, fn_rd, ln_rd;

  // Derived conditions
  logic                        at_limit;
  logic                        key_match, scan_hit, scan_end;
  logic [plbc_pkg::MAXF_W-1:0] fl_limit;
  logic                        fl_last;
  logic                        out_free;
  logic [plbc_pkg::PIN_W-1:0]  pins_inc, pins_dec;
  logic [LW-1:0]               sel_tail;
  logic                        sel_on;

  assign at_limit  = CMPW'(resident) >= CMPW'(max_entries);
  assign key_match = key_rd[plbc_pkg::KEY_W-1]
                   && key_rd[plbc_pkg::KEY_W-2 -: plbc_pkg::DEV_W] == dev_r
                   && key_rd[plbc_pkg::BLK_W-1:0] == blk_r;
  assign scan_hit  = cmp_v && key_match;
  assign scan_end  = cmp_v && !key_match && (cmp_idx == IW'(CAPACITY - 1));
  assign fl_limit  = (max_flushes > plbc_pkg::MAXF_W'(FLUSH_LIMIT))
                   ? plbc_pkg::MAXF_W'(FLUSH_LIMIT) : max_flushes;
  assign fl_last   = (fl_k + 1'b1 == fl_limit) || fh[IW];
  assign out_free  = !out_valid || out_rsp.ready;
  assign pins_inc  = (pins_rd == plbc_pkg::PIN_MAX) ? pins_rd : pins_rd + 1'b1;
  assign pins_dec  = pins_rd - 1'b1;
  assign sel_tail  = pu_lru ? lt : ft;
  assign sel_on    = pu_lru ? lp_rd[LW] : fp_rd[LW];

  assign in_req.ready = (state == plbc_pkg::ST_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      plbc_pkg::ST_INIT:
        if (init_idx == IW'(CAPACITY - 1)) state_next = plbc_pkg::ST_IDLE;
      plbc_pkg::ST_IDLE:
        if (in_req.valid) begin
          priority case (in_req.operation)
            plbc_pkg::OP_GET:   state_next = plbc_pkg::ST_GET;
            plbc_pkg::OP_PUT:   state_next = plbc_pkg::ST_SCAN;
            plbc_pkg::OP_FLUSH: state_next = plbc_pkg::ST_FL_NEXT;
            default:            state_next = plbc_pkg::ST_EMIT;
          endcase
        end
      plbc_pkg::ST_GET:
        if (!at_limit) state_next = plbc_pkg::ST_SCAN;
        else if (lh[IW]) state_next = plbc_pkg::ST_CHK;
        else state_next = plbc_pkg::ST_WALK_RD;
      plbc_pkg::ST_WALK_RD: state_next = plbc_pkg::ST_WALK_CHK;
      plbc_pkg::ST_WALK_CHK:
        if (fl_rd) state_next = plbc_pkg::ST_RM_RD;
        else if (ln_rd[IW]) state_next = plbc_pkg::ST_EV_RD;
        else state_next = plbc_pkg::ST_WALK_RD;
      plbc_pkg::ST_EV_RD:  state_next = plbc_pkg::ST_EV_KEY;
      plbc_pkg::ST_EV_KEY: state_next = plbc_pkg::ST_EMIT;
      plbc_pkg::ST_CHK:
        state_next = at_limit ? plbc_pkg::ST_EMIT : plbc_pkg::ST_SCAN;
      plbc_pkg::ST_SCAN:
        if (scan_hit) begin
          state_next = (op_r == plbc_pkg::OP_GET) ? plbc_pkg::ST_HIT_RD
                                                  : plbc_pkg::ST_PUT_RD;
        end else if (scan_end) begin
          state_next = (op_r == plbc_pkg::OP_GET && free_top != '0)
                     ? plbc_pkg::ST_MISS_RD : plbc_pkg::ST_EMIT;
        end
      plbc_pkg::ST_HIT_RD:  state_next = plbc_pkg::ST_HIT_UPD;
      plbc_pkg::ST_HIT_UPD: state_next = plbc_pkg::ST_RM_RD;
      plbc_pkg::ST_MISS_RD: state_next = plbc_pkg::ST_MISS_WR;
      plbc_pkg::ST_MISS_WR: state_next = plbc_pkg::ST_EMIT;
      plbc_pkg::ST_PUT_RD:  state_next = plbc_pkg::ST_PUT_UPD;
      plbc_pkg::ST_PUT_UPD:
        state_next = (pins_rd == '0) ? plbc_pkg::ST_EMIT : plbc_pkg::ST_PU_RD;
      plbc_pkg::ST_PUT_LRU:
        state_next = (pins_r == '0) ? plbc_pkg::ST_PU_RD : plbc_pkg::ST_EMIT;
      plbc_pkg::ST_FL_NEXT:
        if (fl_k < fl_limit && !fh[IW]) state_next = plbc_pkg::ST_RM_RD;
        else if (fl_k == '0) state_next = plbc_pkg::ST_EMIT;
        else state_next = plbc_pkg::ST_IDLE;
      plbc_pkg::ST_FL_RD:   state_next = plbc_pkg::ST_FL_KEY;
      plbc_pkg::ST_FL_KEY:  state_next = plbc_pkg::ST_EMIT;
      plbc_pkg::ST_RM_RD:   state_next = plbc_pkg::ST_RM_LINK;
      plbc_pkg::ST_RM_LINK: state_next = plbc_pkg::ST_RM_OFF;
      plbc_pkg::ST_RM_OFF:  state_next = rm_ret;
      plbc_pkg::ST_PU_RD:   state_next = plbc_pkg::ST_PU_W1;
      plbc_pkg::ST_PU_W1:   state_next = plbc_pkg::ST_PU_W2;
      plbc_pkg::ST_PU_W2:   state_next = pu_ret;
      plbc_pkg::ST_EMIT:
        if (out_free) state_next = emit_ret;
      default: state_next = plbc_pkg::ST_IDLE;
    endcase
  end

  // Memory port control
  always_comb begin
    key_we = 1'b0;  key_wa = s;  key_wd = '0;  key_ra = s;
    pins_we = 1'b0; pins_wa = s; pins_wd = '0; pins_ra = s;
    fl_we = 1'b0;   fl_wa = s;   fl_wd = 1'b0; fl_ra = s;
    free_we = 1'b0; free_wa = free_top[IW-1:0]; free_wd = s;
    free_ra = free_top[IW-1:0];
    fp_we = 1'b0; fp_wa = s; fp_wd = {1'b0, NIL};
    fn_we = 1'b0; fn_wa = s; fn_wd = NIL;
    lp_we = 1'b0; lp_wa = s; lp_wd = {1'b0, NIL};
    ln_we = 1'b0; ln_wa = s; ln_wd = NIL;
    lk_ra = s;
    unique case (state)
      plbc_pkg::ST_INIT: begin
        key_we  = 1'b1;
        key_wa  = init_idx;
        free_we = 1'b1;
        free_wa = init_idx;
        free_wd = IW'(CAPACITY - 1) - init_idx;
      end
      plbc_pkg::ST_SCAN: key_ra = scan_idx[IW-1:0];
      plbc_pkg::ST_HIT_UPD: begin
        pins_we = 1'b1;
        pins_wd = pins_inc;
        fl_we   = 1'b1;
      end
      plbc_pkg::ST_MISS_WR: begin
        key_we  = 1'b1;
        key_wa  = free_rd;
        key_wd  = {1'b1, dev_r, blk_r};
        pins_we = 1'b1;
        pins_wa = free_rd;
        pins_wd = plbc_pkg::PIN_W'(1);
        fl_we   = 1'b1;
        fl_wa   = free_rd;
      end
      plbc_pkg::ST_PUT_UPD:
        if (pins_rd != '0) begin
          pins_we = 1'b1;
          pins_wd = pins_dec;
          fl_we   = 1'b1;
        end
      plbc_pkg::ST_FL_RD: begin
        fl_we = 1'b1;
        fl_wd = 1'b1;
      end
      plbc_pkg::ST_RM_LINK: begin
        // unlink from neighbors
        if (rm_f && fp_rd[LW]) begin
          fn_we = !fp_rd[IW];
          fn_wa = fp_rd[IW-1:0];
          fn_wd = fn_rd;
          fp_we = !fn_rd[IW];
          fp_wa = fn_rd[IW-1:0];
          fp_wd = {1'b1, fp_rd[LW-1:0]};
        end
        if (rm_l && lp_rd[LW]) begin
          ln_we = !lp_rd[IW];
          ln_wa = lp_rd[IW-1:0];
          ln_wd = ln_rd;
          lp_we = !ln_rd[IW];
          lp_wa = ln_rd[IW-1:0];
          lp_wd = {1'b1, lp_rd[LW-1:0]};
        end
        if (rm_free) begin
          key_we  = 1'b1;
          free_we = (free_top < CW'(CAPACITY));
        end
      end
      plbc_pkg::ST_RM_OFF: begin
        fp_we = fon;
        lp_we = lon;
      end
      plbc_pkg::ST_PU_W1:
        if (!sel_on) begin
          if (pu_lru) begin
            lp_we = 1'b1;
            lp_wd = {1'b1, lt};
            ln_we = 1'b1;
          end else begin
            fp_we = 1'b1;
            fp_wd = {1'b1, ft};
            fn_we = 1'b1;
          end
        end
      plbc_pkg::ST_PU_W2:
        if (!pu_on && !pu_tail[IW]) begin
          if (pu_lru) begin
            ln_we = 1'b1;
            ln_wa = pu_tail[IW-1:0];
            ln_wd = {1'b0, s};
          end else begin
            fn_we = 1'b1;
            fn_wa = pu_tail[IW-1:0];
            fn_wd = {1'b0, s};
          end
        end
      default: ;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= plbc_pkg::ST_INIT;
      init_idx    <= '0;
      free_top    <= CW'(CAPACITY);
      resident    <= '0;
      fh          <= NIL;
      ft          <= NIL;
      lh          <= NIL;
      lt          <= NIL;
      out_valid   <= 1'b0;
      max_entries <= plbc_pkg::MAXE_W'(256);
      max_flushes <= plbc_pkg::MAXF_W'(64);
    end else begin
      state <= state_next;

      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          plbc_pkg::CFG_MAX_ENTRIES: max_entries <= cfg_data;
          plbc_pkg::CFG_MAX_FLUSHES: max_flushes <= cfg_data[plbc_pkg::MAXF_W-1:0];
          default: ;
        endcase
      end

      // drop the result beat once taken
      if (out_valid && out_rsp.ready) out_valid <= 1'b0;

      unique case (state)
        plbc_pkg::ST_INIT: init_idx <= init_idx + 1'b1;
        plbc_pkg::ST_IDLE:
          if (in_req.valid) begin
            op_r     <= in_req.operation;
            dev_r    <= in_req.device;
            blk_r    <= in_req.block_number;
            scan_idx <= '0;
            cmp_v    <= 1'b0;
            fl_k     <= '0;
            {res_status, res_slot, res_dev, res_blk, res_pins, res_last}
                     <= {plbc_pkg::STAT_IDLE, IW'(0), 16'd0, 32'd0, 16'd0, 1'b1};
            emit_ret <= plbc_pkg::ST_IDLE;
          end
        plbc_pkg::ST_GET: s <= lh[IW-1:0];
        plbc_pkg::ST_WALK_CHK:
          if (fl_rd) begin
            rm_f    <= 1'b1;
            rm_l    <= 1'b1;
            rm_free <= 1'b1;
            rm_ret  <= plbc_pkg::ST_CHK;
          end else if (ln_rd[IW]) begin
            s <= lh[IW-1:0];
          end else begin
            s <= ln_rd[IW-1:0];
          end
        plbc_pkg::ST_EV_KEY: begin
          res_status <= plbc_pkg::STAT_WRITEBACK;
          res_slot   <= s;
          res_dev    <= key_rd[plbc_pkg::KEY_W-2 -: plbc_pkg::DEV_W];
          res_blk    <= key_rd[plbc_pkg::BLK_W-1:0];
          res_pins   <= '0;
          res_last   <= 1'b0;
          emit_ret   <= plbc_pkg::ST_RM_RD;
          rm_f       <= 1'b1;
          rm_l       <= 1'b1;
          rm_free    <= 1'b1;
          rm_ret     <= plbc_pkg::ST_CHK;
        end
        plbc_pkg::ST_CHK: begin
          {res_status, res_slot, res_dev, res_blk, res_pins, res_last}
                   <= {plbc_pkg::STAT_FULL, IW'(0), 16'd0, 32'd0, 16'd0, 1'b1};
          emit_ret <= plbc_pkg::ST_IDLE;
        end
        plbc_pkg::ST_SCAN:
          if (scan_hit) begin
            s <= cmp_idx;
          end else if (scan_end) begin
            emit_ret <= plbc_pkg::ST_IDLE;
            if (op_r == plbc_pkg::OP_GET) begin
              {res_status, res_slot, res_dev, res_blk, res_pins, res_last}
                <= {plbc_pkg::STAT_FULL, IW'(0), 16'd0, 32'd0, 16'd0, 1'b1};
              if (free_top != '0) free_top <= free_top - 1'b1;
            end else begin
              {res_status, res_slot, res_dev, res_blk, res_pins, res_last}
                <= {plbc_pkg::STAT_PUT_UNK, IW'(0), 16'd0, 32'd0, 16'd0, 1'b1};
            end
          end else begin
            cmp_v    <= 1'b1;
            cmp_idx  <= scan_idx[IW-1:0];
            scan_idx <= scan_idx + 1'b1;
          end
        plbc_pkg::ST_HIT_UPD: begin
          res_status <= plbc_pkg::STAT_HIT;
          res_slot   <= s;
          res_dev    <= dev_r;
          res_blk    <= blk_r;
          res_pins   <= pins_inc;
          res_last   <= 1'b1;
          emit_ret   <= plbc_pkg::ST_IDLE;
          rm_f       <= 1'b0;
          rm_l       <= 1'b1;
          rm_free    <= 1'b0;
          rm_ret     <= plbc_pkg::ST_EMIT;
        end
        plbc_pkg::ST_MISS_WR: begin
          s          <= free_rd;
          resident   <= resident + 1'b1;
          res_status <= plbc_pkg::STAT_MISS;
          res_slot   <= free_rd;
          res_dev    <= dev_r;
          res_blk    <= blk_r;
          res_pins   <= plbc_pkg::PIN_W'(1);
          res_last   <= 1'b1;
          emit_ret   <= plbc_pkg::ST_IDLE;
        end
        plbc_pkg::ST_PUT_UPD: begin
          res_slot <= s;
          res_dev  <= dev_r;
          res_blk  <= blk_r;
          res_last <= 1'b1;
          emit_ret <= plbc_pkg::ST_IDLE;
          if (pins_rd == '0) begin
            res_status <= plbc_pkg::STAT_PUT_UNPIN;
            res_pins   <= '0;
          end else begin
            res_status <= plbc_pkg::STAT_PUT_DONE;
            res_pins   <= pins_dec;
            pins_r     <= pins_dec;
            pu_lru     <= 1'b0;
            pu_ret     <= plbc_pkg::ST_PUT_LRU;
          end
        end
        plbc_pkg::ST_PUT_LRU: begin
          pu_lru <= 1'b1;
          pu_ret <= plbc_pkg::ST_EMIT;
        end
        plbc_pkg::ST_FL_NEXT:
          if (fl_k < fl_limit && !fh[IW]) begin
            s       <= fh[IW-1:0];
            rm_f    <= 1'b1;
            rm_l    <= 1'b0;
            rm_free <= 1'b0;
            rm_ret  <= plbc_pkg::ST_FL_RD;
          end
        plbc_pkg::ST_FL_KEY: begin
          res_status <= plbc_pkg::STAT_WRITEBACK;
          res_slot   <= s;
          res_dev    <= key_rd[plbc_pkg::KEY_W-2 -: plbc_pkg::DEV_W];
          res_blk    <= key_rd[plbc_pkg::BLK_W-1:0];
          res_pins   <= pins_rd;
          res_last   <= fl_last;
          fl_k       <= fl_k + 1'b1;
          emit_ret   <= fl_last ? plbc_pkg::ST_IDLE : plbc_pkg::ST_FL_NEXT;
        end
        plbc_pkg::ST_RM_LINK: begin
          fon <= rm_f && fp_rd[LW];
          lon <= rm_l && lp_rd[LW];
          // advance list ends past the removed slot
          if (rm_f && fp_rd[LW]) begin
            if (fp_rd[IW]) fh <= fn_rd;
            if (fn_rd[IW]) ft <= fp_rd[LW-1:0];
          end
          if (rm_l && lp_rd[LW]) begin
            if (lp_rd[IW]) lh <= ln_rd;
            if (ln_rd[IW]) lt <= lp_rd[LW-1:0];
          end
          if (rm_free) begin
            if (free_top < CW'(CAPACITY)) free_top <= free_top + 1'b1;
            if (resident != '0) resident <= resident - 1'b1;
          end
        end
        plbc_pkg::ST_PU_W1: begin
          pu_on   <= sel_on;
          pu_tail <= sel_tail;
          if (!sel_on) begin
            if (pu_lru) begin
              lt <= {1'b0, s};
              if (lt[IW]) lh <= {1'b0, s};
            end else begin
              ft <= {1'b0, s};
              if (ft[IW]) fh <= {1'b0, s};
            end
          end
        end
        plbc_pkg::ST_EMIT:
          if (out_free) out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (state == plbc_pkg::ST_EMIT && out_free) begin
      out_rsp.status     <= res_status;
      out_rsp.slot       <= plbc_pkg::SLOT_W'(res_slot);
      out_rsp.out_device <= res_dev;
      out_rsp.out_block  <= res_blk;
      out_rsp.pin_count  <= res_pins;
      out_rsp.last       <= res_last;
    end
  end

  assign out_rsp.valid = out_valid;

  // Slot state memories
  plbc_ram #(.WIDTH(plbc_pkg::KEY_W), .DEPTH(CAPACITY)) u_key (
    .clk(clk), .we(key_we), .waddr(key_wa), .wdata(key_wd), .raddr(key_ra), .rdata(key_rd));
  plbc_ram #(.WIDTH(plbc_pkg::PIN_W), .DEPTH(CAPACITY)) u_pins (
    .clk(clk), .we(pins_we), .waddr(pins_wa), .wdata(pins_wd), .raddr(pins_ra),
    .rdata(pins_rd));
  plbc_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_flushed (
    .clk(clk), .we(fl_we), .waddr(fl_wa), .wdata(fl_wd), .raddr(fl_ra), .rdata(fl_rd));
  plbc_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_free (
    .clk(clk), .we(free_we), .waddr(free_wa), .wdata(free_wd), .raddr(free_ra),
    .rdata(free_rd));

  // List link memories: prev words carry the on-list flag
  plbc_ram #(.WIDTH(LW + 1), .DEPTH(CAPACITY)) u_fprev (
    .clk(clk), .we(fp_we), .waddr(fp_wa), .wdata(fp_wd), .raddr(lk_ra), .rdata(fp_rd));
  plbc_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_fnext (
    .clk(clk), .we(fn_we), .waddr(fn_wa), .wdata(fn_wd), .raddr(lk_ra), .rdata(fn_rd));
  plbc_ram #(.WIDTH(LW + 1), .DEPTH(CAPACITY)) u_lprev (
    .clk(clk), .we(lp_we), .waddr(lp_wa), .wdata(lp_wd), .raddr(lk_ra), .rdata(lp_rd));
  plbc_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_lnext (
    .clk(clk), .we(ln_we), .waddr(ln_wa), .wdata(ln_wd), .raddr(lk_ra), .rdata(ln_rd));

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for pinned_lru_block_cache: directed table, then random phases.
// Depends on plbc_pkg, plbc_in_if, plbc_out_if and the block's RTL.
module testbench;
  import plbc_pkg::*;

  localparam int SLOTS       = 256;
  localparam int FLUSH_CAP   = 64;
  localparam int QUIET_LIMIT = 40000;
  localparam int DRAIN_WAIT  = 600;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic [DEV_W-1:0]  dev;
    logic [BLK_W-1:0]  blk;
    logic [PIN_W-1:0]  pins;
    logic              last;
  } rsp_t;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [DEV_W-1:0] dev;
    logic [BLK_W-1:0] blk;
    bit               typed;
    rsp_t             rsp;
  } row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CIDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  plbc_in_if  in_req();
  plbc_out_if out_rsp();

  pinned_lru_block_cache i_dut (
    .clk(clk), .rst(rst), .in_req(in_req), .out_rsp(out_rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Cache mirror
  int unsigned     lim_entries;
  int unsigned     lim_flushes;
  bit              m_valid [SLOTS];
  logic [DEV_W-1:0] m_dev  [SLOTS];
  logic [BLK_W-1:0] m_blk  [SLOTS];
  int unsigned     m_pins  [SLOTS];
  bit              m_flushed [SLOTS];
  int              flush_order[$];
  int              lru_order[$];
  int              free_slots [SLOTS];
  int              free_top;
  int              resident;

  rsp_t   pending_rsp[$];
  row_t   rows[$];
  int     errors;
  int     req_beats;
  int     rsp_beats;
  int     evictions;
  int     fulls;
  int     quiet;
  int     send_idle;
  int     recv_idle;
  logic [DEV_W-1:0] key_dev [24];
  logic [BLK_W-1:0] key_blk [24];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit on_list(ref int q[$], input int s);
    foreach (q[i]) if (q[i] == s) return 1;
    return 0;
  endfunction

  function automatic void drop_from(ref int q[$], input int s);
    foreach (q[i]) begin
      if (q[i] == s) begin
        q.delete(i);
        return;
      end
    end
  endfunction

  function automatic void push_rsp(logic [STAT_W-1:0] st, int s, logic [DEV_W-1:0] d,
                                   logic [BLK_W-1:0] b, int unsigned p, bit l);
    rsp_t r;
    r.status = st;
    r.slot   = s[SLOT_W-1:0];
    r.dev    = d;
    r.blk    = b;
    r.pins   = p[PIN_W-1:0];
    r.last   = l;
    pending_rsp.push_back(r);
  endfunction

  function automatic void mirror_reset();
    lim_entries = SLOTS;
    lim_flushes = FLUSH_CAP;
    for (int i = 0; i < SLOTS; i++) begin
      m_valid[i]    = 0;
      m_flushed[i]  = 0;
      free_slots[i] = SLOTS - 1 - i;
    end
    flush_order.delete();
    lru_order.delete();
    free_top = SLOTS;
    resident = 0;
  endfunction

  function automatic void release_slot(int s);
    drop_from(flush_order, s);
    drop_from(lru_order, s);
    m_valid[s] = 0;
    if (free_top < SLOTS) free_slots[free_top++] = s;
    if (resident > 0) resident--;
  endfunction

  function automatic int lookup(logic [DEV_W-1:0] d, logic [BLK_W-1:0] b);
    for (int i = 0; i < SLOTS; i++)
      if (m_valid[i] && m_dev[i] == d && m_blk[i] == b) return i;
    return -1;
  endfunction

  // Work out every result beat one request causes and update the mirror
  function automatic void predict_cache(logic [OP_W-1:0] op, logic [DEV_W-1:0] d,
                                        logic [BLK_W-1:0] b);
    int s;
    int victim;
    int k;
    int unsigned lim;
    s = -1;
    victim = -1;
    k = 0;
    if (op == OP_GET) begin
      if (resident >= lim_entries) begin
        // drop the oldest clean unpinned block, else write back the LRU head
        foreach (lru_order[i]) begin
          if (m_flushed[lru_order[i]]) begin
            victim = lru_order[i];
            break;
          end
        end
        if (victim >= 0) begin
          release_slot(victim);
        end else if (lru_order.size() > 0) begin
          victim = lru_order[0];
          m_flushed[victim] = 1;
          push_rsp(STAT_WRITEBACK, victim, m_dev[victim], m_blk[victim], 0, 0);
          release_slot(victim);
        end
        if (victim >= 0) evictions++;
        if (resident >= lim_entries) begin
          push_rsp(STAT_FULL, 0, '0, '0, 0, 1);
          return;
        end
      end
      s = lookup(d, b);
      if (s >= 0) begin
        if (m_pins[s] < 65535) m_pins[s]++;
        drop_from(lru_order, s);
        m_flushed[s] = 0;
        push_rsp(STAT_HIT, s, d, b, m_pins[s], 1);
      end else if (free_top == 0) begin
        push_rsp(STAT_FULL, 0, '0, '0, 0, 1);
      end else begin
        s = free_slots[--free_top];
        m_valid[s]   = 1;
        m_dev[s]     = d;
        m_blk[s]     = b;
        m_pins[s]    = 1;
        m_flushed[s] = 0;
        resident++;
        push_rsp(STAT_MISS, s, d, b, 1, 1);
      end
    end else if (op == OP_PUT) begin
      s = lookup(d, b);
      if (s < 0) begin
        push_rsp(STAT_PUT_UNK, 0, '0, '0, 0, 1);
      end else if (m_pins[s] == 0) begin
        push_rsp(STAT_PUT_UNPIN, s, d, b, 0, 1);
      end else begin
        m_pins[s]--;
        m_flushed[s] = 0;
        if (!on_list(flush_order, s)) flush_order.push_back(s);
        if (m_pins[s] == 0 && !on_list(lru_order, s)) lru_order.push_back(s);
        push_rsp(STAT_PUT_DONE, s, d, b, m_pins[s], 1);
      end
    end else begin
      if (op == OP_FLUSH) begin
        lim = (lim_flushes > FLUSH_CAP) ? FLUSH_CAP : lim_flushes;
        while (k < lim && flush_order.size() > 0) begin
          s = flush_order.pop_front();
          m_flushed[s] = 1;
          push_rsp(STAT_WRITEBACK, s, m_dev[s], m_blk[s], m_pins[s], 0);
          k++;
        end
      end
      if (k > 0) pending_rsp[$].last = 1;
      else push_rsp(STAT_IDLE, 0, '0, '0, 0, 1);
    end
  endfunction

  function automatic void add_row(logic [OP_W-1:0] op, logic [DEV_W-1:0] d,
                                  logic [BLK_W-1:0] b, bit typed,
                                  logic [STAT_W-1:0] st, int s, logic [DEV_W-1:0] rd,
                                  logic [BLK_W-1:0] rb, int unsigned p);
    row_t r;
    r.op = op;
    r.dev = d;
    r.blk = b;
    r.typed = typed;
    r.rsp = '{status: st, slot: s[SLOT_W-1:0], dev: rd, blk: rb, pins: p[PIN_W-1:0],
              last: 1'b1};
    rows.push_back(r);
  endfunction

  // Hand one request beat over, with an optional gap first
  task automatic send_req(logic [OP_W-1:0] op, logic [DEV_W-1:0] d, logic [BLK_W-1:0] b,
                          bit typed, rsp_t typed_rsp);
    if ($urandom_range(99) < send_idle) begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_req.valid        <= 1'b1;
    in_req.operation    <= op;
    in_req.device       <= d;
    in_req.block_number <= b;
    do @(posedge clk); while (!in_req.ready);
    req_beats++;
    if (typed) begin
      // keep the mirror in step, but check against the typed beat
      predict_cache(op, d, b);
      void'(pending_rsp.pop_back());
      pending_rsp.push_back(typed_rsp);
    end else begin
      predict_cache(op, d, b);
    end
  endtask

  task automatic drain();
    in_req.valid <= 1'b0;
    while (pending_rsp.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_limits(int unsigned entries, int unsigned flushes);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAX_ENTRIES;
    cfg_data  <= entries[CFG_W-1:0];
    @(posedge clk);
    cfg_index <= CFG_MAX_FLUSHES;
    cfg_data  <= flushes[CFG_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    lim_entries = entries;
    lim_flushes = flushes;
  endtask

  // Mostly gets and puts on a small key set, with stray keys, flushes and spare codes mixed in
  task automatic run_random(int count);
    int pick;
    int idx;
    logic [OP_W-1:0]  op;
    logic [DEV_W-1:0] d;
    logic [BLK_W-1:0] b;
    for (int i = 0; i < 24; i++) begin
      key_dev[i] = $urandom();
      key_blk[i] = $urandom();
    end
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 45) op = OP_GET;
      else if (pick < 82) op = OP_PUT;
      else if (pick < 97) op = OP_FLUSH;
      else op = OP_SPARE;
      idx = $urandom_range(23);
      if ($urandom_range(99) < 10) begin
        d = $urandom();
        b = $urandom();
      end else begin
        d = key_dev[idx];
        b = key_blk[idx];
      end
      send_req(op, d, b, 0, '0);
    end
  endtask

  // Receiver stalls
  always @(posedge clk) begin
    if (rst) out_rsp.ready <= 1'b0;
    else out_rsp.ready <= ($urandom_range(99) >= recv_idle);
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    rsp_t got;
    rsp_t want;
    if (!rst && out_rsp.valid && out_rsp.ready) begin
      got = '{status: out_rsp.status, slot: out_rsp.slot, dev: out_rsp.out_device,
              blk: out_rsp.out_block, pins: out_rsp.pin_count, last: out_rsp.last};
      rsp_beats++;
      if (got.status == STAT_FULL) fulls++;
      if (pending_rsp.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: %p", got);
      end else begin
        want = pending_rsp.pop_front();
        if (got.status != want.status || got.slot != want.slot || got.dev != want.dev ||
            got.blk != want.blk || got.pins != want.pins || got.last != want.last) begin
          errors++;
          if (errors <= 10) $display("result mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results pending", quiet,
                 pending_rsp.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    req_beats = 0;
    rsp_beats = 0;
    evictions = 0;
    fulls = 0;
    quiet = 0;
    send_idle = 13;
    recv_idle = 64;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_MAX_ENTRIES;
    cfg_data = '0;
    in_req.valid = 1'b0;
    in_req.operation = OP_GET;
    in_req.device = '0;
    in_req.block_number = '0;
    mirror_reset();

    // directed part, default limits
    add_row(OP_FLUSH, 16'h0, 32'h0, 1, STAT_IDLE, 0, '0, '0, 0);
    add_row(OP_PUT, 16'h1234, 32'h5678, 1, STAT_PUT_UNK, 0, '0, '0, 0);
    add_row(OP_SPARE, 16'hFFFF, 32'hFFFFFFFF, 1, STAT_IDLE, 0, '0, '0, 0);
    add_row(OP_GET, 16'h0, 32'h0, 1, STAT_MISS, 0, 16'h0, 32'h0, 1);
    add_row(OP_GET, 16'hFFFF, 32'hFFFFFFFF, 1, STAT_MISS, 1, 16'hFFFF, 32'hFFFFFFFF, 1);
    add_row(OP_GET, 16'h0, 32'h0, 1, STAT_HIT, 0, 16'h0, 32'h0, 2);
    add_row(OP_PUT, 16'h0, 32'h0, 1, STAT_PUT_DONE, 0, 16'h0, 32'h0, 1);
    add_row(OP_PUT, 16'h0, 32'h0, 1, STAT_PUT_DONE, 0, 16'h0, 32'h0, 0);
    add_row(OP_PUT, 16'h0, 32'h0, 1, STAT_PUT_UNPIN, 0, 16'h0, 32'h0, 0);
    add_row(OP_FLUSH, 16'h0, 32'h0, 1, STAT_WRITEBACK, 0, 16'h0, 32'h0, 0);
    add_row(OP_PUT, 16'hFFFF, 32'hFFFFFFFF, 1, STAT_PUT_DONE, 1, 16'hFFFF, 32'hFFFFFFFF, 0);
    add_row(OP_GET, 16'hAAAA, 32'h55555555, 0, STAT_HIT, 0, '0, '0, 0);
    add_row(OP_GET, 16'h5555, 32'hAAAAAAAA, 0, STAT_HIT, 0, '0, '0, 0);
    add_row(OP_GET, 16'h0, 32'h1, 0, STAT_HIT, 0, '0, '0, 0);
    add_row(OP_PUT, 16'hAAAA, 32'h55555555, 0, STAT_HIT, 0, '0, '0, 0);
    add_row(OP_PUT, 16'h5555, 32'hAAAAAAAA, 0, STAT_HIT, 0, '0, '0, 0);
    add_row(OP_GET, 16'h0, 32'h0, 0, STAT_HIT, 0, '0, '0, 0);
    add_row(OP_FLUSH, 16'h0, 32'h0, 0, STAT_HIT, 0, '0, '0, 0);
    add_row(OP_GET, 16'h1, 32'h0, 0, STAT_HIT, 0, '0, '0, 0);
    add_row(OP_PUT, 16'h0, 32'h1, 0, STAT_HIT, 0, '0, '0, 0);
    add_row(OP_FLUSH, 16'h0, 32'h0, 0, STAT_HIT, 0, '0, '0, 0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) send_req(rows[i].op, rows[i].dev, rows[i].blk, rows[i].typed,
                               rows[i].rsp);
    drain();

    // tight caches, first with one writeback per pass: eviction and full answers
    set_limits(4, 1);
    run_random(90);
    drain();
    set_limits(1, 64);
    run_random(80);
    drain();

    // swap the idling sides
    send_idle = 64;
    recv_idle = 13;
    set_limits(3, 2);
    run_random(80);
    drain();

    // no idling, a roomy cache, then a tight one with the widest flush setting
    send_idle = 0;
    recv_idle = 0;
    set_limits(256, 64);
    run_random(100);
    drain();
    set_limits(2, 127);
    run_random(70);
    drain();

    $display("covered %0d requests, %0d result beats, %0d evictions, %0d full answers",
             req_beats, rsp_beats, evictions, fulls);
    $display("limits swept from 1 to 256 entries and 1 to 127 writebacks per pass");
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_rsp.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
